[src/sobel_l1_edge_magnitude_macros.svh]
// ---------------------------------------------------------------------------
// Sobel L1 edge magnitude - assertion macros
// Shared concurrent assertion shorthands for the edge magnitude block.
// ---------------------------------------------------------------------------
`ifndef SOBEL_L1_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_L1_EDGE_MAGNITUDE_MACROS_SVH

// same-cycle implication
`define SLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sle_pkg.sv]
// ---------------------------------------------------------------------------
// Sobel L1 edge magnitude - package
// Request types, register codes, window column type and sizing constants.
// ---------------------------------------------------------------------------
package sle_pkg;

    localparam int SLE_MAX_WIDTH = 1024;
    localparam int LINE_W_BITS   = 11;
    localparam int ROW_BITS      = 12;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [LINE_W_BITS-1:0] LINE_WIDTH_RESET   = 11'd640;
    localparam logic [ROW_BITS-1:0]    FRAME_HEIGHT_RESET = 12'd480;

    // register indexes
    localparam logic CFG_LINE_WIDTH   = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // request op codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic [7:0] t_pix;

    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    typedef struct packed {
        logic op;
        t_pix pixel_in;
    } t_in_req;

    typedef struct packed {
        t_pix edge_out;
        logic frame_end;
    } t_out_req;

    // which window columns feed the kernels
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_ROWEND = 2'd0;
    localparam t_mode MODE_FIRST  = 2'd1;
    localparam t_mode MODE_MID    = 2'd2;
    localparam t_mode MODE_TAIL   = 2'd3;

endpackage

[src/sobel_l1_edge_magnitude.sv]
// Pipeline: a result passes stage 1, stage 2, stage 3 and the output register after its request.
// Throughput: one request per cycle unless the output stalls or a clear runs, set by the window cell shift.
// Image lag: each result belongs to the pixel line_width + 1 requests back.
// Reset: config returns to 640 x 480; both line stores are then cleared,
// one address a cycle over all MAX_WIDTH addresses, with o_in_ready low; config writes still taken.
// ---------------------------------------------------------------------------
// Sobel L1 edge magnitude - top level
// Line-buffered 3x3 Sobel, saturated L1 magnitude, replicated borders.
// ---------------------------------------------------------------------------
`include "sobel_l1_edge_magnitude_macros.svh"

module sobel_l1_edge_magnitude import sle_pkg::*; #(
    parameter int MAX_WIDTH = SLE_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_req                  i_in_req,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_req                 o_out_req
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CW > LINE_W_BITS) ? CW : LINE_W_BITS;

    function automatic t_pix clip_abs(logic signed [10:0] v);
        logic [10:0] a;
        a = v[10] ? 11'(-v) : 11'(v);
        return (a > 11'd255) ? 8'd255 : a[7:0];
    endfunction

    // configuration
    logic [LINE_W_BITS-1:0] r_line_width;
    logic [ROW_BITS-1:0]    r_frame_height;
    logic [WW-1:0]          lw_ext;
    logic [CW-1:0]          eff_w;
    logic [ROW_BITS-1:0]    eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_data[LINE_W_BITS-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[ROW_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign lw_ext = WW'(r_line_width);

    always_comb begin
        if (lw_ext < WW'(3)) begin
            eff_w = CW'(3);
        end else if (lw_ext > WW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(lw_ext);
        end
    end

    assign eff_h = (r_frame_height < 12'd3) ? 12'd3 : r_frame_height;

    // line store clear after reset
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // pipeline handshake
    logic r_s1_v, r_s2_v, r_s3_v, r_out_v;
    logic out_free, s3_free, s2_free;
    logic s1_adv, s2_adv, s3_adv;
    logic accept;

    assign out_free   = !r_out_v || i_out_ready;
    assign s3_free    = !r_s3_v || out_free;
    assign s2_free    = !r_s2_v || s3_free;
    assign s3_adv     = r_s3_v && out_free;
    assign s2_adv     = r_s2_v && s3_free;
    assign s1_adv     = r_s1_v && s2_free;
    assign o_in_ready = !r_clearing && (!r_s1_v || s2_free);
    assign accept     = i_in_valid && o_in_ready;

    // position tracking and request decode
    logic [CW-1:0]       r_col;
    logic [ROW_BITS-1:0] r_row;
    logic                r_tail;

    logic [CW-1:0]       col_a, col_b;
    logic [ROW_BITS-1:0] row_a;
    logic                tail_a, drain, is_skip, is_pix, emit;
    t_mode               mode;
    logic [CW-1:0]       n_col;
    logic [ROW_BITS-1:0] n_row;
    logic                n_tail;

    always_comb begin
        col_a  = r_col;
        row_a  = r_row;
        tail_a = r_tail;
        if (!r_tail && r_col >= eff_w) begin
            col_a = '0;
            if (r_row >= eff_h) begin
                tail_a = 1'b1;
            end else begin
                row_a = r_row + 1'b1;
            end
        end

        drain   = row_a >= eff_h;
        is_skip = !tail_a && !drain && (i_in_req.op == OP_DRAIN);
        is_pix  = !tail_a && !is_skip;
        col_b   = col_a + 1'b1;

        if (tail_a) begin
            emit = 1'b1;
            mode = MODE_TAIL;
        end else if (col_a == '0) begin
            emit = row_a >= 12'd2;
            mode = MODE_ROWEND;
        end else begin
            emit = row_a >= 12'd1;
            mode = (col_a == CW'(1)) ? MODE_FIRST : MODE_MID;
        end

        n_col  = col_a;
        n_row  = row_a;
        n_tail = tail_a;
        if (tail_a) begin
            n_col  = '0;
            n_row  = '0;
            n_tail = 1'b0;
        end else if (is_pix) begin
            if (col_b >= eff_w) begin
                n_col = '0;
                if (row_a >= eff_h) begin
                    n_tail = 1'b1;
                end else begin
                    n_row = row_a + 1'b1;
                end
            end else begin
                n_col = col_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_tail <= 1'b0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_tail <= n_tail;
        end
    end

    // stage 1: line store read data arrives
    logic          r_s1_tail, r_s1_drain, r_s1_toprep, r_s1_emit;
    t_pix          r_s1_pix;
    logic [AW-1:0] r_s1_addr;
    t_mode         r_s1_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= (accept && !is_skip) || (r_s1_v && !s1_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !is_skip) begin
            r_s1_tail   <= tail_a;
            r_s1_drain  <= drain;
            r_s1_toprep <= row_a == 12'd1;
            r_s1_emit   <= emit;
            r_s1_pix    <= i_in_req.pixel_in;
            r_s1_addr   <= col_a[AW-1:0];
            r_s1_mode   <= mode;
        end
    end

    t_pix          up_rd, mid_rd;
    t_col          new_col;
    logic          ram_we, shift;
    logic [AW-1:0] ram_waddr;
    t_pix          up_wdata, mid_wdata;

    assign new_col.mid = mid_rd;
    assign new_col.bot = r_s1_drain ? mid_rd : r_s1_pix;
    assign new_col.top = r_s1_toprep ? mid_rd : up_rd;

    assign shift     = s1_adv && !r_s1_tail;
    assign ram_we    = r_clearing || shift;
    assign ram_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign up_wdata  = r_clearing ? 8'd0 : new_col.mid;
    assign mid_wdata = r_clearing ? 8'd0 : new_col.bot;

    sle_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (up_wdata),
        .i_re    (accept && is_pix),
        .i_raddr (col_a[AW-1:0]),
        .o_rdata (up_rd)
    );

    sle_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (mid_wdata),
        .i_re    (accept && is_pix),
        .i_raddr (col_a[AW-1:0]),
        .o_rdata (mid_rd)
    );

    // window: cell 0 oldest, cell 2 newest
    t_col       cell_in  [3];
    t_col       cell_out [3];
    logic [9:0] vs       [3];

    assign cell_in[2] = new_col;

    for (genvar g = 0; g < 3; g++) begin : g_cell
        if (g < 2) begin : g_link
            assign cell_in[g] = cell_out[g+1];
        end
        sle_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_col   (cell_in[g]),
            .o_col   (cell_out[g]),
            .o_vsum  (vs[g])
        );
    end

    // stage 2: kernels over the selected columns
    t_mode r_s2_mode;
    logic  r_s2_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= (s1_adv && r_s1_emit) || (r_s2_v && !s2_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_s2_mode <= r_s1_mode;
            r_s2_end  <= r_s1_tail;
        end
    end

    t_col              sel_l, sel_m, sel_r;
    logic [9:0]        vs_l, vs_r;
    logic signed [10:0] gx, gy;

    always_comb begin
        case (r_s2_mode)
            MODE_ROWEND: begin
                sel_l = cell_out[0]; sel_m = cell_out[1]; sel_r = cell_out[1];
                vs_l  = vs[0];       vs_r  = vs[1];
            end
            MODE_FIRST: begin
                sel_l = cell_out[1]; sel_m = cell_out[1]; sel_r = cell_out[2];
                vs_l  = vs[1];       vs_r  = vs[2];
            end
            MODE_TAIL: begin
                sel_l = cell_out[1]; sel_m = cell_out[2]; sel_r = cell_out[2];
                vs_l  = vs[1];       vs_r  = vs[2];
            end
            default: begin
                sel_l = cell_out[0]; sel_m = cell_out[1]; sel_r = cell_out[2];
                vs_l  = vs[0];       vs_r  = vs[2];
            end
        endcase
        gx = $signed({1'b0, vs_r}) - $signed({1'b0, vs_l});
        gy = $signed({3'b000, sel_l.bot} + {2'b00, sel_m.bot, 1'b0} + {3'b000, sel_r.bot})
           - $signed({3'b000, sel_l.top} + {2'b00, sel_m.top, 1'b0} + {3'b000, sel_r.top});
    end

    // stage 3: gradients registered
    logic signed [10:0] r_s3_gx, r_s3_gy;
    logic               r_s3_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= s2_adv || (r_s3_v && !s3_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_s3_gx  <= gx;
            r_s3_gy  <= gy;
            r_s3_end <= r_s2_end;
        end
    end

    // output register: saturated L1 magnitude
    logic [8:0] mag;
    t_out_req   r_out_req;

    assign mag = {1'b0, clip_abs(r_s3_gx)} + {1'b0, clip_abs(r_s3_gy)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= s3_adv || (r_out_v && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            r_out_req.edge_out  <= mag[8] ? 8'd255 : mag[7:0];
            r_out_req.frame_end <= r_s3_end;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_req   = r_out_req;

    `SLE_ASSERT_IMP(a_clear_idle, i_clk, i_rst_n, r_clearing,
                    !r_s1_v && !r_s2_v && !r_s3_v && !r_out_v, "pipeline busy during clear")
    `SLE_ASSERT_IMP(a_tail_col0, i_clk, i_rst_n, r_tail, r_col == '0,
                    "tail pending off column zero")
    `SLE_ASSERT_NXT(a_s1_hold, i_clk, i_rst_n, r_s1_v && !s1_adv,
                    r_s1_v && $stable(r_s1_addr) && $stable(r_s1_mode), "stage 1 lost request")

endmodule

[src/sle_ram.sv]
// ---------------------------------------------------------------------------
// Sobel L1 edge magnitude - generic RAM
// One write port, one read port, registered read data held when not read.
// ---------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/sle_cell.sv]
// ---------------------------------------------------------------------------
// Sobel L1 edge magnitude - window column cell
// Holds one 3-pixel column, passes it on each shift, forms its 1-2-1 sum.
// ---------------------------------------------------------------------------
module sle_cell import sle_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  t_col       i_col,
    output t_col       o_col,
    output logic [9:0] o_vsum
);

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col  = r_col;
    assign o_vsum = {2'b00, r_col.top} + {1'b0, r_col.mid, 1'b0} + {2'b00, r_col.bot};

endmodule

[tb/sle_checker.sv]
// ---------------------------------------------------------------------------
// Sobel L1 edge magnitude - scoreboard
// Watches the config port and both request channels. It keeps its own
// line stores, 3x3 window and frame position, predicts the edge results
// that the accepted requests cause and compares each returned result with
// the oldest prediction.
// ---------------------------------------------------------------------------
module sle_checker import sle_pkg::*; #(
    parameter int MAX_W = SLE_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  t_in_req                  i_in_req,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  t_out_req                 i_out_req,
    output int                       o_fail_cnt,
    output int                       o_pending,
    output int                       o_results
);

    t_pix                 upper_row [MAX_W];
    t_pix                 mid_row   [MAX_W];
    t_col                 win       [3];
    int unsigned          col_pos;
    int unsigned          row_pos;
    bit                   tail_due;
    logic [LINE_W_BITS-1:0] width_reg;
    logic [ROW_BITS-1:0]    height_reg;
    t_out_req             edges_due [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR @%0t: %s: got %0d, want %0d", $time, what, got, want);
        o_fail_cnt++;
    endtask

    function automatic int sat_abs(input int v);
        if (v < 0) begin
            v = -v;
        end
        return (v > 255) ? 255 : v;
    endfunction

    function automatic t_pix sobel_l1(input t_col lf, input t_col cn, input t_col rt);
        int gx, gy, s;
        gx = (int'(rt.top) + 2 * int'(rt.mid) + int'(rt.bot))
           - (int'(lf.top) + 2 * int'(lf.mid) + int'(lf.bot));
        gy = (int'(lf.bot) + 2 * int'(cn.bot) + int'(rt.bot))
           - (int'(lf.top) + 2 * int'(cn.top) + int'(rt.top));
        s = sat_abs(gx) + sat_abs(gy);
        return t_pix'((s > 255) ? 255 : s);
    endfunction

    function automatic void close_row(input int unsigned h);
        col_pos = 0;
        if (row_pos >= h) begin
            tail_due = 1'b1;
        end else begin
            row_pos++;
        end
    endfunction

    function automatic void shift_col(input t_col v);
        win[0] = win[1];
        win[1] = win[2];
        win[2] = v;
    endfunction

    task automatic predict_edge(input t_in_req req);
        int unsigned w, h, c, r;
        t_col        v;
        t_out_req    res;
        bit          drain, emit;
        w = (width_reg < 3) ? 3 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        h = (height_reg < 3) ? 3 : height_reg;
        emit = 1'b0;
        if (!tail_due && col_pos >= w) begin
            close_row(h);
        end
        if (tail_due) begin
            res.edge_out  = sobel_l1(win[1], win[2], win[2]);
            res.frame_end = 1'b1;
            edges_due.push_back(res);
            col_pos  = 0;
            row_pos  = 0;
            tail_due = 1'b0;
            return;
        end
        drain = (row_pos >= h);
        if (!drain && req.op == OP_DRAIN) begin
            return;
        end
        c     = col_pos;
        r     = row_pos;
        v.mid = mid_row[c];
        v.bot = drain ? v.mid : req.pixel_in;
        v.top = (r == 1) ? v.mid : upper_row[c];
        upper_row[c] = v.mid;
        mid_row[c]   = v.bot;
        if (c == 0) begin
            if (r >= 2) begin
                res.edge_out = sobel_l1(win[1], win[2], win[2]);
                emit = 1'b1;
            end
            shift_col(v);
        end else begin
            shift_col(v);
            if (r >= 1) begin
                res.edge_out = sobel_l1((c == 1) ? win[1] : win[0], win[1], win[2]);
                emit = 1'b1;
            end
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            close_row(h);
        end
        if (emit) begin
            res.frame_end = 1'b0;
            edges_due.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_W; i++) begin
                upper_row[i] = '0;
                mid_row[i]   = '0;
            end
            for (int i = 0; i < 3; i++) begin
                win[i] = '0;
            end
            col_pos    = 0;
            row_pos    = 0;
            tail_due   = 1'b0;
            width_reg  = LINE_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            edges_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LINE_WIDTH) begin
                    width_reg = i_cfg_data[LINE_W_BITS-1:0];
                end else begin
                    height_reg = i_cfg_data[ROW_BITS-1:0];
                end
            end
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (edges_due.size() == 0) begin
                    report_mismatch("result with nothing pending, edge_out",
                                    i_out_req.edge_out, -1);
                end else begin
                    want = edges_due.pop_front();
                    if (i_out_req.edge_out !== want.edge_out) begin
                        report_mismatch("edge_out", i_out_req.edge_out, want.edge_out);
                    end
                    if (i_out_req.frame_end !== want.frame_end) begin
                        report_mismatch("frame_end", i_out_req.frame_end, want.frame_end);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_edge(i_in_req);
            end
        end
        o_pending = edges_due.size();
    end

endmodule

[tb/sobel_l1_edge_magnitude_tb.sv]
// ---------------------------------------------------------------------------
// Sobel L1 edge magnitude - testbench top
// Drives pixel and drain requests in small frames under random idling on
// both channels, walks the line width and frame height through their
// extremes, cuts lines and frames short, and takes the verdict from the
// scoreboard.
// ---------------------------------------------------------------------------
module sobel_l1_edge_magnitude_tb import sle_pkg::*;;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 240;

    logic                     i_clk     = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic                     cfg_idx   = CFG_LINE_WIDTH;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    t_in_req                  in_req    = '0;
    logic                     out_ready = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    t_out_req                 out_req;

    int                       fail_cnt, pending, results;
    int                       item_cnt  = 0;
    int                       frame_cnt = 0;
    int                       cycle_cnt = 0;
    int                       stall_left = 0;
    bit                       src_idle  = 1'b0;
    bit                       snk_idle  = 1'b0;
    logic [CFG_DATA_BITS-1:0] w_raw_reg;
    int unsigned              cur_w, cur_h;

    sobel_l1_edge_magnitude u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req)
    );

    sle_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_req    (in_req),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_req   (out_req),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending),
        .o_results   (results)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // sink side backpressure in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (snk_idle && $urandom_range(0, 7) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic write_cfg(input logic [CFG_DATA_BITS-1:0] w_raw,
                             input logic [CFG_DATA_BITS-1:0] h_raw);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LINE_WIDTH;
        cfg_data <= w_raw;
        @(posedge i_clk);
        cfg_idx  <= CFG_FRAME_HEIGHT;
        cfg_data <= h_raw;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        w_raw_reg = w_raw;
        cur_w = (w_raw[LINE_W_BITS-1:0] < 3) ? 3 :
                ((w_raw[LINE_W_BITS-1:0] > SLE_MAX_WIDTH) ? SLE_MAX_WIDTH
                                                          : w_raw[LINE_W_BITS-1:0]);
        cur_h = (h_raw < 3) ? 3 : h_raw;
    endtask

    task automatic send_req(input logic op, input t_pix pix, input bit counted);
        t_in_req req;
        req.op       = op;
        req.pixel_in = pix;
        if (src_idle && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
        if (counted) begin
            item_cnt++;
        end
    endtask

    // pixel rows, with the odd drain request that the block must ignore
    task automatic feed_pixels(input int n);
        t_pix pix;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_req(OP_DRAIN, t_pix'($urandom_range(0, 255)), 1'b0);
            end
            if ($urandom_range(0, 3) == 0) begin
                pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end else begin
                pix = t_pix'($urandom_range(0, 255));
            end
            send_req(OP_PIXEL, pix, 1'b1);
        end
    endtask

    // drain row plus the closing request; pixel requests here count as drains
    task automatic feed_drains(input int n);
        for (int i = 0; i < n; i++) begin
            send_req(($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN,
                     t_pix'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        int rnd_start, rows, sel, guard;
        logic [CFG_DATA_BITS-1:0] w_pick, h_pick;

        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        // smallest frame: step edge that saturates both gradients
        write_cfg(12'd3, 12'd3);
        send_req(OP_DRAIN, 8'h5A, 1'b0);
        for (int i = 0; i < 9; i++) begin
            send_req(OP_PIXEL, (i % 3 == 2 || i / 3 == 2) ? 8'hFF : 8'h00, 1'b1);
        end
        send_req(OP_DRAIN, 8'h00, 1'b1);
        send_req(OP_PIXEL, 8'hA5, 1'b1);
        send_req(OP_DRAIN, 8'hFF, 1'b1);
        send_req(OP_DRAIN, 8'h00, 1'b1);
        wait_idle();
        frame_cnt++;

        // undersized registers clamp to 3 x 3; flat image
        write_cfg(12'd2, 12'd1);
        for (int i = 0; i < 9; i++) begin
            send_req(OP_PIXEL, 8'hFF, 1'b1);
        end
        feed_drains(4);
        wait_idle();
        frame_cnt++;

        // widest line, then the line is cut mid row
        src_idle = 1'b1;
        snk_idle = 1'b1;
        write_cfg(12'hFFF, 12'd3);
        feed_pixels(SLE_MAX_WIDTH + 6);
        wait_idle();
        write_cfg(12'd5, 12'd3);
        feed_pixels(5);
        feed_drains(6);
        wait_idle();
        frame_cnt++;

        // tallest frame, then the frame is cut after five rows
        write_cfg(12'd3, 12'hFFF);
        feed_pixels(15);
        wait_idle();
        write_cfg(12'd3, 12'd0);
        feed_drains(4);
        wait_idle();
        frame_cnt++;

        rnd_start = item_cnt;
        while (item_cnt - rnd_start < RANDOM_ITEMS) begin
            if (item_cnt - rnd_start > RANDOM_ITEMS * 4 / 5) begin
                src_idle = 1'b0;
                snk_idle = 1'b0;
            end else begin
                src_idle = 1'($urandom_range(0, 1));
                snk_idle = 1'($urandom_range(0, 1));
            end
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                w_pick = CFG_DATA_BITS'($urandom_range(0, 2));
            end else if (sel < 3) begin
                w_pick = CFG_DATA_BITS'($urandom_range(11, 40));
            end else begin
                w_pick = CFG_DATA_BITS'($urandom_range(3, 10));
            end
            h_pick = ($urandom_range(0, 7) == 0) ? CFG_DATA_BITS'($urandom_range(0, 2))
                                                 : CFG_DATA_BITS'($urandom_range(3, 7));
            if (frame_cnt == 4 || $urandom_range(0, 3) != 0) begin
                write_cfg(w_pick, h_pick);
            end
            if (cur_h >= 4 && $urandom_range(0, 5) == 0) begin
                rows = $urandom_range(3, cur_h - 1);
                feed_pixels(rows * cur_w);
                wait_idle();
                write_cfg(w_raw_reg, CFG_DATA_BITS'($urandom_range(0, rows)));
            end else begin
                feed_pixels(cur_h * cur_w);
            end
            feed_drains(cur_w + 1);
            wait_idle();
            frame_cnt++;
        end

        in_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        $display("ran %0d frames, %0d requests, %0d edge results checked", frame_cnt,
                 item_cnt, results);
        $display("line width 3..%0d and frame height 3..4095, cut lines and frames, stalls",
                 SLE_MAX_WIDTH);
        if (pending != 0) begin
            $display("ERROR: %0d predicted results never arrived", pending);
        end
        if (fail_cnt == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/sle_pkg.sv
src/sle_ram.sv
src/sle_cell.sv
src/sobel_l1_edge_magnitude.sv
tb/sle_checker.sv
tb/sobel_l1_edge_magnitude_tb.sv
